### rtl/imdfw_pkg.sv
package imdfw_pkg;

  // defaults for the top level parameters
  localparam int NUM_PALETTES_DEF  = 14;
  localparam int BYTES_PER_ROW_DEF = 80;
  localparam int ROW_PAIRS_DEF     = 100;
  localparam int BANK_STRIDE_DEF   = 8192;

  // fixed field widths
  localparam int VRAM_AW      = 14;
  localparam int SHADOW_DEPTH = 1 << VRAM_AW;
  localparam int PIX_W        = 8;
  localparam int CHAN_W       = 8;
  localparam int PAL_W        = 4;
  localparam int THR_W        = 10;
  localparam int LEVEL_W      = 2;
  localparam int PIX_PER_ITEM = 4;
  localparam int DATA_W       = PIX_PER_ITEM * LEVEL_W;
  // palette number and colour index side by side, room for sixteen palettes
  localparam int LVL_AW       = PAL_W + PIX_W;
  localparam int QUEUE_DEPTH  = 2;

  // item opcodes
  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_PIXELS = 1'b1;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_PALETTE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_THRESHOLD  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_THRESHOLD = 2'd2;

  localparam logic [PAL_W-1:0] ACTIVE_PALETTE_RST = 4'd0;
  localparam logic [THR_W-1:0] LOW_THRESHOLD_RST  = 10'd32;
  localparam logic [THR_W-1:0] HIGH_THRESHOLD_RST = 10'd64;

  // one classified item as it waits between front and back
  typedef struct packed {
    logic                                  is_pixels;
    logic                                  pal_ok;
    logic [LEVEL_W-1:0]                    level;
    logic [PIX_PER_ITEM-1:0][LVL_AW-1:0]   lvl_addr;
    logic [VRAM_AW-1:0]                    vram_address;
  } entry_t;

endpackage

### rtl/imdfw_ifs.sv
interface imdfw_pix_if import imdfw_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              opcode;
  logic [PAL_W-1:0]  palette_select;
  logic [PIX_W-1:0]  color_index;
  logic [CHAN_W-1:0] red_level;
  logic [CHAN_W-1:0] green_level;
  logic [CHAN_W-1:0] blue_level;
  logic [PIX_W-1:0]  pixel_a;
  logic [PIX_W-1:0]  pixel_b;
  logic [PIX_W-1:0]  pixel_c;
  logic [PIX_W-1:0]  pixel_d;

  modport source (
    output valid, opcode, palette_select, color_index, red_level, green_level, blue_level,
           pixel_a, pixel_b, pixel_c, pixel_d,
    input  ready
  );
  modport sink (
    input  valid, opcode, palette_select, color_index, red_level, green_level, blue_level,
           pixel_a, pixel_b, pixel_c, pixel_d,
    output ready
  );
  modport mon (
    input valid, ready, opcode, palette_select, color_index, red_level, green_level,
          blue_level, pixel_a, pixel_b, pixel_c, pixel_d
  );
endinterface

interface imdfw_vram_if import imdfw_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [VRAM_AW-1:0] vram_address;
  logic [DATA_W-1:0]  vram_data;

  modport source (output valid, vram_address, vram_data, input ready);
  modport sink   (input valid, vram_address, vram_data, output ready);
  modport mon    (input valid, ready, vram_address, vram_data);
endinterface

interface imdfw_cfg_if import imdfw_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [THR_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
  modport mon    (input valid, ready, index, data);
endinterface

### rtl/imdfw_ram.sv
module imdfw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/imdfw_front.sv
module imdfw_front import imdfw_pkg::*; #(
  parameter int NUM_PALETTES  = NUM_PALETTES_DEF,
  parameter int BYTES_PER_ROW = BYTES_PER_ROW_DEF,
  parameter int ROW_PAIRS     = ROW_PAIRS_DEF,
  parameter int BANK_STRIDE   = BANK_STRIDE_DEF
) (
  input  logic            clk,
  input  logic            rst,
  imdfw_pix_if.sink       items,
  imdfw_cfg_if.sink       cfg,
  input  logic            clearing,
  input  logic            queue_full,
  output logic            push,
  output entry_t          push_entry
);

  localparam int COL_W  = (BYTES_PER_ROW > 1) ? $clog2(BYTES_PER_ROW) : 1;
  localparam int PAIR_W = (ROW_PAIRS > 1) ? $clog2(ROW_PAIRS) : 1;
  localparam logic [COL_W-1:0]   COL_LAST  = COL_W'(BYTES_PER_ROW - 1);
  localparam logic [PAIR_W-1:0]  PAIR_LAST = PAIR_W'(ROW_PAIRS - 1);
  localparam logic [VRAM_AW-1:0] ROW_STEP  = VRAM_AW'(BYTES_PER_ROW);
  localparam logic [VRAM_AW-1:0] BANK_OFS  = VRAM_AW'(BANK_STRIDE);
  localparam logic [PAL_W:0]     PAL_LIMIT = (PAL_W + 1)'(NUM_PALETTES);

  logic [PAL_W-1:0]   active_palette;
  logic [THR_W-1:0]   low_threshold;
  logic [THR_W-1:0]   high_threshold;
  logic [COL_W-1:0]   column;
  logic [PAIR_W-1:0]  pair;
  logic               odd_row;
  logic [VRAM_AW-1:0] row_base;

  logic [THR_W-1:0]   sum;
  logic [PIX_W-1:0]   pix [PIX_PER_ITEM];
  logic               is_pixels;

  assign cfg.ready   = 1'b1;
  assign items.ready = !queue_full && !clearing;
  assign push        = items.valid && items.ready;
  assign is_pixels   = (items.opcode == OP_PIXELS);

  assign sum = THR_W'(items.red_level) + THR_W'(items.green_level) + THR_W'(items.blue_level);
  assign pix[0] = items.pixel_a;
  assign pix[1] = items.pixel_b;
  assign pix[2] = items.pixel_c;
  assign pix[3] = items.pixel_d;

  always_comb begin
    push_entry.is_pixels = is_pixels;
    push_entry.pal_ok    = is_pixels ? ({1'b0, active_palette} < PAL_LIMIT)
                                     : ({1'b0, items.palette_select} < PAL_LIMIT);
    push_entry.level     = {sum > high_threshold, sum > low_threshold};
    for (int k = 0; k < PIX_PER_ITEM; k++) begin
      push_entry.lvl_addr[k] = {active_palette, pix[k]};
    end
    if (!is_pixels) begin
      push_entry.lvl_addr[0] = {items.palette_select, items.color_index};
    end
    push_entry.vram_address = row_base + VRAM_AW'(column) + (odd_row ? BANK_OFS : '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active_palette <= ACTIVE_PALETTE_RST;
      low_threshold  <= LOW_THRESHOLD_RST;
      high_threshold <= HIGH_THRESHOLD_RST;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_ACTIVE_PALETTE: active_palette <= cfg.data[PAL_W-1:0];
        REG_LOW_THRESHOLD:  low_threshold  <= cfg.data;
        REG_HIGH_THRESHOLD: high_threshold <= cfg.data;
        default: ;
      endcase
    end
  end

  // raster position, row base kept as a running sum of row pairs
  always_ff @(posedge clk) begin
    if (rst) begin
      column   <= '0;
      pair     <= '0;
      odd_row  <= 1'b0;
      row_base <= '0;
    end else if (push && is_pixels) begin
      if (column == COL_LAST) begin
        column <= '0;
        if (odd_row) begin
          odd_row <= 1'b0;
          if (pair == PAIR_LAST) begin
            pair     <= '0;
            row_base <= '0;
          end else begin
            pair     <= pair + 1'b1;
            row_base <= row_base + ROW_STEP;
          end
        end else begin
          odd_row <= 1'b1;
        end
      end else begin
        column <= column + 1'b1;
      end
    end
  end

endmodule

### rtl/imdfw_queue.sv
module imdfw_queue import imdfw_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t push_entry,
  input  logic   pop,
  output entry_t head,
  output logic   full,
  output logic   empty
);

  localparam int QAW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW  = $clog2(DEPTH + 1);
  localparam logic [QAW-1:0] PTR_LAST = QAW'(DEPTH - 1);

  entry_t           slots [DEPTH];
  logic [QAW-1:0]   wr_ptr;
  logic [QAW-1:0]   rd_ptr;
  logic [CW-1:0]    count;

  assign head  = slots[rd_ptr];
  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: ;
      endcase
    end
  end

endmodule

### rtl/imdfw_back.sv
module imdfw_back import imdfw_pkg::*; #(
  parameter int NUM_PALETTES = NUM_PALETTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_empty,
  input  entry_t      head,
  output logic        pop,
  output logic        clearing,
  imdfw_vram_if.source vram
);

  localparam int LVL_DEPTH  = NUM_PALETTES * 256;
  localparam int LVL_RAM_AW = $clog2(LVL_DEPTH);

  logic [VRAM_AW-1:0] clear_ptr;

  logic               b1_valid;
  logic               b1_pal_ok;
  logic [VRAM_AW-1:0] b1_address;
  logic [PIX_PER_ITEM-1:0][LEVEL_W-1:0] lvl_rdata;
  logic [DATA_W-1:0]  shadow_rdata;
  logic [DATA_W-1:0]  b1_data;
  logic [DATA_W-1:0]  shadow_cur;

  logic               last_wr_valid;
  logic [VRAM_AW-1:0] last_wr_address;
  logic [DATA_W-1:0]  last_wr_data;

  logic               out_valid;
  logic [VRAM_AW-1:0] out_address;
  logic [DATA_W-1:0]  out_data;

  logic changed, out_free, b1_go, advance, issue, issue_pix, issue_load, b1_write;
  logic               shadow_we;
  logic [VRAM_AW-1:0] shadow_waddr;
  logic [DATA_W-1:0]  shadow_wdata;

  assign b1_data = b1_pal_ok ? {lvl_rdata[0], lvl_rdata[1], lvl_rdata[2], lvl_rdata[3]} : '0;
  // the shadow write of the previous item lands on the same edge as this read
  assign shadow_cur = (last_wr_valid && last_wr_address == b1_address) ? last_wr_data
                                                                      : shadow_rdata;
  assign changed    = (b1_data != shadow_cur);
  assign out_free   = !out_valid || vram.ready;
  assign b1_go      = b1_valid && (!changed || out_free);
  assign b1_write   = b1_go && changed;
  assign advance    = !b1_valid || b1_go;
  assign issue      = advance && !q_empty && !clearing;
  assign issue_pix  = issue && head.is_pixels;
  assign issue_load = issue && !head.is_pixels && head.pal_ok;
  assign pop        = issue;

  assign shadow_we    = clearing || b1_write;
  assign shadow_waddr = clearing ? clear_ptr : b1_address;
  assign shadow_wdata = clearing ? '0 : b1_data;

  // one copy of the level table per pixel lane, all written alike
  for (genvar k = 0; k < PIX_PER_ITEM; k++) begin : g_lvl
    imdfw_ram #(
      .WIDTH (LEVEL_W),
      .DEPTH (LVL_DEPTH)
    ) u_lvl_ram (
      .clk   (clk),
      .we    (issue_load),
      .waddr (head.lvl_addr[0][LVL_RAM_AW-1:0]),
      .wdata (head.level),
      .re    (issue_pix),
      .raddr (head.lvl_addr[k][LVL_RAM_AW-1:0]),
      .rdata (lvl_rdata[k])
    );
  end

  imdfw_ram #(
    .WIDTH (DATA_W),
    .DEPTH (SHADOW_DEPTH)
  ) u_shadow_ram (
    .clk   (clk),
    .we    (shadow_we),
    .waddr (shadow_waddr),
    .wdata (shadow_wdata),
    .re    (issue_pix),
    .raddr (head.vram_address),
    .rdata (shadow_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing      <= 1'b1;
      clear_ptr     <= '0;
      b1_valid      <= 1'b0;
      last_wr_valid <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (clearing) begin
        clear_ptr <= clear_ptr + 1'b1;
        if (clear_ptr == '1) begin
          clearing <= 1'b0;
        end
      end
      if (advance) begin
        b1_valid      <= issue_pix;
        last_wr_valid <= b1_write;
      end
      if (b1_write) begin
        out_valid <= 1'b1;
      end else if (vram.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue_pix) begin
      b1_pal_ok  <= head.pal_ok;
      b1_address <= head.vram_address;
    end
    if (advance) begin
      last_wr_address <= b1_address;
      last_wr_data    <= b1_data;
    end
    if (b1_write) begin
      out_address <= b1_address;
      out_data    <= b1_data;
    end
  end

  assign vram.valid        = out_valid;
  assign vram.vram_address = out_address;
  assign vram.vram_data    = out_data;

endmodule

### rtl/indexed_to_mono_dither_frame_writer_unit.sv
// Indexed-to-monochrome frame writer: turns 8-bit colour indices into bytes for a one-bit
// interlaced display and emits a memory write only when a byte really changes. A load item
// (opcode 0) stores two level bits for one palette colour: r+g+b above low_threshold and above
// high_threshold; loads to a palette number at or beyond NUM_PALETTES are dropped. A pixel item
// (opcode 1) carries four raster-order indices; each becomes two display bits, high bit first,
// pixel_a in the top pair. Addresses follow an internal row/column counter in raster order,
// with odd rows BANK_STRIDE up, wrapped to 14 bits. After reset the block zeroes all 16384
// entries of its shadow copy of display memory, with items.ready low; configuration writes are
// taken at any time and must only happen while the block is idle. After that an item is
// taken every cycle while vram keeps up, and a changed byte passes a queue slot, the level
// and shadow reads and the output register before vram sees it; the rate is set by the
// one read port of the shadow memory and of each of the four level table copies, each used
// once per pixel item.
module indexed_to_mono_dither_frame_writer_unit import imdfw_pkg::*; #(
  parameter int NUM_PALETTES  = NUM_PALETTES_DEF,
  parameter int BYTES_PER_ROW = BYTES_PER_ROW_DEF,
  parameter int ROW_PAIRS     = ROW_PAIRS_DEF,
  parameter int BANK_STRIDE   = BANK_STRIDE_DEF
) (
  input  logic         clk,
  input  logic         rst,
  imdfw_pix_if.sink    items,
  imdfw_cfg_if.sink    cfg,
  imdfw_vram_if.source vram
);

  // front to queue
  logic   push;
  entry_t push_entry;
  // queue to back
  entry_t head;
  logic   pop;
  logic   q_full;
  logic   q_empty;
  // back holds the input off while the shadow copy is being zeroed
  logic   clearing;

  // front: config registers, threshold compare for loads, raster counters for pixels
  imdfw_front #(
    .NUM_PALETTES  (NUM_PALETTES),
    .BYTES_PER_ROW (BYTES_PER_ROW),
    .ROW_PAIRS     (ROW_PAIRS),
    .BANK_STRIDE   (BANK_STRIDE)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .items      (items),
    .cfg        (cfg),
    .clearing   (clearing),
    .queue_full (q_full),
    .push       (push),
    .push_entry (push_entry)
  );

  // short queue so the input keeps flowing while the output stalls
  imdfw_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .full       (q_full),
    .empty      (q_empty)
  );

  // back: level table writes and reads, shadow compare and update, output register
  imdfw_back #(
    .NUM_PALETTES (NUM_PALETTES)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (q_empty),
    .head     (head),
    .pop      (pop),
    .clearing (clearing),
    .vram     (vram)
  );

endmodule

### rtl/imdfw_checker.sv
module imdfw_checker import imdfw_pkg::*; #(
  parameter int BYTES_PER_ROW = BYTES_PER_ROW_DEF,
  parameter int ROW_PAIRS     = ROW_PAIRS_DEF,
  parameter int BANK_STRIDE   = BANK_STRIDE_DEF
) (
  input logic               clk,
  input logic               rst,
  input logic               items_ready,
  input logic               vram_valid,
  input logic               vram_ready,
  input logic [VRAM_AW-1:0] vram_address,
  input logic [DATA_W-1:0]  vram_data
);

  localparam int  FRAME_BYTES = BYTES_PER_ROW * ROW_PAIRS;
  localparam bit  NO_ALIAS    = (FRAME_BYTES <= BANK_STRIDE) &&
                                (BANK_STRIDE + FRAME_BYTES <= SHADOW_DEPTH);

  // shadow zeroing starts right after reset
  a_ready_low_after_reset: assert property (@(posedge clk) rst |=> !items_ready)
    else $error("items.ready high right after reset");

  a_no_result_after_reset: assert property (@(posedge clk) rst |=> !vram_valid)
    else $error("vram.valid high right after reset");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    vram_valid && !vram_ready |=> vram_valid && $stable(vram_address) &&
                                  $stable(vram_data))
    else $error("stalled result changed");

  // each address lies in the even or the odd bank frame
  a_address_in_frame: assert property (@(posedge clk) disable iff (rst)
    vram_valid && NO_ALIAS |->
      (int'(vram_address) < FRAME_BYTES) ||
      (int'(vram_address) >= BANK_STRIDE &&
       int'(vram_address) < BANK_STRIDE + FRAME_BYTES))
    else $error("vram_address outside display frame");

endmodule

bind indexed_to_mono_dither_frame_writer_unit imdfw_checker #(
  .BYTES_PER_ROW (BYTES_PER_ROW),
  .ROW_PAIRS     (ROW_PAIRS),
  .BANK_STRIDE   (BANK_STRIDE)
) u_imdfw_checker (
  .clk          (clk),
  .rst          (rst),
  .items_ready  (items.ready),
  .vram_valid   (vram.valid),
  .vram_ready   (vram.ready),
  .vram_address (vram.vram_address),
  .vram_data    (vram.vram_data)
);
